// ----- hw/rtl/mcm_pkg.sv -----
// Shared types and constants of the motor command mapper.
package mcm_pkg;

  localparam int DATA_W    = 16;
  localparam int REG_IDX_W = 3;

  typedef logic [DATA_W-1:0] word_t;

  // motor_mode codes
  localparam logic [1:0] MODE_SINGLE = 2'd0;
  localparam logic [1:0] MODE_DUAL   = 2'd1;
  localparam logic [1:0] MODE_BRIDGE = 2'd2;
  localparam logic [1:0] MODE_SERVO  = 2'd3;

  // action codes of a request
  localparam logic [1:0] ACT_SET   = 2'd0;
  localparam logic [1:0] ACT_START = 2'd1;
  localparam logic [1:0] ACT_STOP  = 2'd2;

  // direction codes
  localparam logic [1:0] DIR_STOP = 2'd0;
  localparam logic [1:0] DIR_FWD  = 2'd1;
  localparam logic [1:0] DIR_REV  = 2'd2;

  // configuration register indexes
  localparam logic [REG_IDX_W-1:0] REG_MODE       = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_DUTY_FLOOR = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_DUTY_CEIL  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_ANGLE_MIN  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_ANGLE_MAX  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_PULSE_MIN  = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_PULSE_MAX  = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_OPTIONS    = 3'd7;

  // bridge_options bits and bridge pin bits
  localparam int OPT_SWAP  = 0;
  localparam int OPT_BRAKE = 1;
  localparam int OPT_STBY  = 2;
  localparam int PIN_IN1   = 0;
  localparam int PIN_IN2   = 1;
  localparam int PIN_STBY  = 2;

  // defaults and fallbacks
  localparam word_t DUTY_FULL     = 16'hFFFF;
  localparam word_t DEF_PULSE_MIN = 16'd5000;
  localparam word_t DEF_PULSE_MAX = 16'd25000;
  localparam logic signed [DATA_W-1:0] DEF_ANGLE_MIN = 16'sd0;
  localparam logic signed [DATA_W-1:0] DEF_ANGLE_MAX = 16'sd18000;

endpackage

// ----- hw/rtl/mcm_mul.sv -----
// Bit-serial shift-add multiplier, one multiplier bit per cycle, LSB first.
module mcm_mul #(
  parameter int B_W = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [mcm_pkg::DATA_W-1:0]      a,
  input  logic [B_W-1:0]                  b,
  output logic                            done,
  output logic [mcm_pkg::DATA_W+B_W-1:0]  product
);
  import mcm_pkg::*;

  localparam int P_W   = DATA_W + B_W;
  localparam int CNT_W = $clog2(B_W + 1);

  logic [P_W-1:0]    acc;
  logic [DATA_W-1:0] a_q;
  logic [CNT_W-1:0]  count;
  logic              busy;
  logic [DATA_W:0]   sum;

  // upper half gets the multiplicand when the bit shifting out is set
  assign sum = {1'b0, acc[P_W-1:B_W]} + (acc[0] ? {1'b0, a_q} : '0);
  assign product = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        acc   <= {{DATA_W{1'b0}}, b};
        a_q   <= a;
        count <= CNT_W'(B_W);
        busy  <= 1'b1;
      end else if (busy) begin
        acc   <= {sum, acc[B_W-1:1]};
        count <= count - 1'b1;
        if (count == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- hw/rtl/mcm_div.sv -----
// Restoring divider, one quotient bit per cycle; quotient known to fit DATA_W bits.
module mcm_div #(
  parameter int N_W = 34,
  parameter int D_W = 17
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [N_W-1:0]              num,
  input  logic [D_W-1:0]              den,
  output logic                        done,
  output logic [mcm_pkg::DATA_W-1:0]  quotient
);
  import mcm_pkg::*;

  localparam int CNT_W = $clog2(DATA_W + 1);

  logic [D_W-1:0]    rem;
  logic [D_W-1:0]    den_q;
  logic [DATA_W-1:0] quo;
  logic [CNT_W-1:0]  count;
  logic              busy;
  logic [D_W:0]      trial;
  logic [D_W+1:0]    diff;
  logic              ge;

  // quo starts as the low dividend bits and fills with quotient bits
  assign trial = {rem, quo[DATA_W-1]};
  assign diff  = {1'b0, trial} - {2'b00, den_q};
  assign ge    = ~diff[D_W+1];
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        // upper dividend part is below den by construction
        rem   <= D_W'(num[N_W-1:DATA_W]);
        quo   <= num[DATA_W-1:0];
        den_q <= den;
        count <= CNT_W'(DATA_W);
        busy  <= 1'b1;
      end else if (busy) begin
        rem   <= ge ? diff[D_W-1:0] : trial[D_W-1:0];
        quo   <= {quo[DATA_W-2:0], ge};
        count <= count - 1'b1;
        if (count == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- hw/rtl/motor_command_mapper.sv -----
// Motor and servo command mapper: config registers, sequencer, drive state, result register.
//
//  channel   handshake            payload
//  config    cfg_we               cfg_index, cfg_data
//  command   cmd_valid/cmd_stall  action, command
//  result    res_valid/res_stall  main_duty .. applied_command
//
// Start, stop and unused action codes go from idle straight to the write step. A set-output
// request runs the serial multiplier over an MB_W-bit operand (MB_W = max(COMMAND_WIDTH-1, 16))
// and then the serial divider for a 16-bit quotient before its write step.
// Reset is synchronous: drive stopped, registers at their defaults.
// One request is worked at a time; a new one is taken while the last result waits.
// A stalled result holds the sequencer in its final step.
module motor_command_mapper #(
  parameter int COMMAND_WIDTH = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [mcm_pkg::REG_IDX_W-1:0]       cfg_index,
  input  logic [mcm_pkg::DATA_W-1:0]          cfg_data,
  input  logic                                cmd_valid,
  output logic                                cmd_stall,
  input  logic [1:0]                          action,
  input  logic signed [COMMAND_WIDTH-1:0]     command,
  output logic                                res_valid,
  input  logic                                res_stall,
  output logic [mcm_pkg::DATA_W-1:0]          main_duty,
  output logic [mcm_pkg::DATA_W-1:0]          reverse_duty,
  output logic [mcm_pkg::DATA_W-1:0]          pulse_width,
  output logic                                pin_in1,
  output logic                                pin_in2,
  output logic                                pin_standby,
  output logic [1:0]                          direction,
  output logic                                running,
  output logic signed [COMMAND_WIDTH-1:0]     applied_command
);
  import mcm_pkg::*;

  localparam int W   = COMMAND_WIDTH;
  localparam int MB_W = (W - 1 > DATA_W) ? W - 1 : DATA_W;
  localparam int P_W  = DATA_W + MB_W;
  localparam int N_W  = P_W + 2;
  localparam int D_W  = (W - 1 > DATA_W + 1) ? W - 1 : DATA_W + 1;
  localparam int E_W  = (W > DATA_W) ? W : DATA_W;

  localparam logic [W-1:0]   FS      = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0]   NEG_FS  = {1'b1, {(W-2){1'b0}}, 1'b1};
  localparam logic [W-1:0]   MOST_NEG = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-2:0]   HALF_FS = {1'b0, {(W-2){1'b1}}};

  typedef enum logic [2:0] {S_IDLE, S_LOAD, S_MUL, S_ADD, S_DIV, S_WRITE} state_t;

  // configuration
  logic [1:0]               motor_mode;
  word_t                    duty_floor, duty_ceil, pulse_min, pulse_max;
  logic signed [DATA_W-1:0] angle_min, angle_max;
  logic [2:0]               bridge_options;

  // drive state
  logic                     running_flag;
  logic [1:0]               direction_state;
  word_t                    main_duty_reg, reverse_duty_reg, pulse_reg;
  logic [2:0]               bridge_pins;
  logic signed [W-1:0]      last_command;

  state_t                   state;
  logic [1:0]               act_q;
  logic signed [W-1:0]      cmd_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      motor_mode     <= MODE_SINGLE;
      duty_floor     <= '0;
      duty_ceil      <= DUTY_FULL;
      angle_min      <= DEF_ANGLE_MIN;
      angle_max      <= DEF_ANGLE_MAX;
      pulse_min      <= DEF_PULSE_MIN;
      pulse_max      <= DEF_PULSE_MAX;
      bridge_options <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MODE:       motor_mode     <= cfg_data[1:0];
        REG_DUTY_FLOOR: duty_floor     <= cfg_data;
        REG_DUTY_CEIL:  duty_ceil      <= cfg_data;
        REG_ANGLE_MIN:  angle_min      <= cfg_data;
        REG_ANGLE_MAX:  angle_max      <= cfg_data;
        REG_PULSE_MIN:  pulse_min      <= cfg_data;
        REG_PULSE_MAX:  pulse_max      <= cfg_data;
        REG_OPTIONS:    bridge_options <= cfg_data[2:0];
      endcase
    end
  end

  // effective ranges after fallbacks
  word_t                    dmax_raw, dmin_e, dmax_e, pmin_e, pmax_e;
  logic signed [DATA_W-1:0] amin_e, amax_e;
  logic                     duty_bad, ang_bad, pls_bad;
  word_t                    drange, prange, span;
  logic [DATA_W:0]          span_full;

  assign dmax_raw = (duty_ceil == '0) ? DUTY_FULL : duty_ceil;
  assign duty_bad = duty_floor > dmax_raw;
  assign dmin_e   = duty_bad ? '0 : duty_floor;
  assign dmax_e   = duty_bad ? DUTY_FULL : dmax_raw;
  assign ang_bad  = angle_max <= angle_min;
  assign amin_e   = ang_bad ? DEF_ANGLE_MIN : angle_min;
  assign amax_e   = ang_bad ? DEF_ANGLE_MAX : angle_max;
  assign pls_bad  = pulse_max <= pulse_min;
  assign pmin_e   = pls_bad ? DEF_PULSE_MIN : pulse_min;
  assign pmax_e   = pls_bad ? DEF_PULSE_MAX : pulse_max;
  assign drange   = dmax_e - dmin_e;
  assign prange   = pmax_e - pmin_e;
  assign span_full = (DATA_W+1)'(amax_e) - (DATA_W+1)'(amin_e);
  assign span     = span_full[DATA_W-1:0];

  logic servo, bridge;
  assign servo  = motor_mode == MODE_SERVO;
  assign bridge = motor_mode == MODE_BRIDGE;

  // speed clamp and magnitude
  logic signed [W-1:0] spd;
  logic [W-1:0]        spd_abs;
  logic [W-2:0]        mag;
  logic                spd_pos, spd_neg;

  always_comb begin
    if (motor_mode == MODE_SINGLE && cmd_q[W-1]) begin
      spd = '0;
    end else if (cmd_q == MOST_NEG) begin
      spd = NEG_FS;
    end else begin
      spd = cmd_q;
    end
  end
  assign spd_abs = spd[W-1] ? (~spd + 1'b1) : spd;
  assign mag     = spd_abs[W-2:0];
  assign spd_neg = spd[W-1];
  assign spd_pos = ~spd[W-1] && (spd != '0);

  // angle clamp and offset from the low end
  logic signed [E_W-1:0] cmd_ext, amin_ext, amax_ext, ang;
  logic signed [E_W:0]   ang_diff;

  assign cmd_ext  = E_W'(cmd_q);
  assign amin_ext = E_W'(amin_e);
  assign amax_ext = E_W'(amax_e);
  assign ang = (cmd_ext < amin_ext) ? amin_ext : ((cmd_ext > amax_ext) ? amax_ext : cmd_ext);
  assign ang_diff = (E_W+1)'(ang) - (E_W+1)'(amin_ext);

  // arithmetic units
  logic                mul_start, mul_done, div_start, div_done;
  word_t               mul_a, quotient;
  logic [MB_W-1:0]     mul_b;
  logic [P_W-1:0]      product;
  logic [N_W-1:0]      div_num;
  logic [D_W-1:0]      div_den;

  assign mul_start = state == S_LOAD;
  assign div_start = state == S_ADD;
  assign mul_a = servo ? prange : drange;
  assign mul_b = servo ? MB_W'(ang_diff[DATA_W-1:0]) : MB_W'(mag);
  // rounding term: half the divisor
  assign div_num = servo ? (N_W'({product, 1'b0}) + N_W'(span))
                         : (N_W'(product) + N_W'(HALF_FS));
  assign div_den = servo ? D_W'({span, 1'b0}) : D_W'(FS);

  mcm_mul #(.B_W(MB_W)) u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       (mul_a),
    .b       (mul_b),
    .done    (mul_done),
    .product (product)
  );

  mcm_div #(.N_W(N_W), .D_W(D_W)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .num      (div_num),
    .den      (div_den),
    .done     (div_done),
    .quotient (quotient)
  );

  // state after the request
  word_t               duty, main_n, rev_n, pulse_n;
  logic [2:0]          pins_n, fwd_pins, rev_pins, stop_pins;
  logic [1:0]          dir_n;
  logic                run_n, swap, brake;
  logic signed [W-1:0] last_n;

  assign swap  = bridge_options[OPT_SWAP];
  assign brake = bridge_options[OPT_BRAKE];
  assign duty  = (mag == '0) ? '0 : dmin_e + quotient;
  assign fwd_pins  = {1'b1, swap, ~swap};
  assign rev_pins  = {1'b1, ~swap, swap};
  assign stop_pins = {bridge_pins[PIN_STBY], brake, brake};

  always_comb begin
    main_n  = main_duty_reg;
    rev_n   = reverse_duty_reg;
    pulse_n = pulse_reg;
    pins_n  = bridge_pins;
    dir_n   = direction_state;
    run_n   = running_flag;
    last_n  = last_command;
    unique case (act_q)
      ACT_SET: begin
        if (servo) begin
          pulse_n = pmin_e + quotient;
          dir_n   = DIR_STOP;
          last_n  = W'(ang);
        end else begin
          last_n = spd;
          if (spd_pos) begin
            if (bridge) pins_n = fwd_pins;
            main_n = duty;
            rev_n  = '0;
            dir_n  = DIR_FWD;
          end else if (spd_neg) begin
            if (bridge) begin
              pins_n = rev_pins;
              main_n = duty;
              rev_n  = '0;
            end else begin
              main_n = '0;
              rev_n  = duty;
            end
            dir_n = DIR_REV;
          end else begin
            main_n = '0;
            rev_n  = '0;
            if (bridge) pins_n = stop_pins;
            dir_n = DIR_STOP;
          end
        end
      end
      ACT_START: begin
        run_n            = 1'b1;
        pins_n[PIN_STBY] = 1'b1;
      end
      ACT_STOP: begin
        main_n  = '0;
        rev_n   = '0;
        pulse_n = '0;
        pins_n  = brake ? stop_pins : 3'b000;
        run_n   = 1'b0;
        dir_n   = DIR_STOP;
        last_n  = '0;
      end
      default: begin
      end
    endcase
  end

  logic res_free;
  assign res_free  = ~res_valid | ~res_stall;
  assign cmd_stall = state != S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      res_valid        <= 1'b0;
      running_flag     <= 1'b0;
      direction_state  <= DIR_STOP;
      main_duty_reg    <= '0;
      reverse_duty_reg <= '0;
      pulse_reg        <= '0;
      bridge_pins      <= '0;
      last_command     <= '0;
    end else begin
      // the final step sets res_valid itself
      if (res_valid && !res_stall && state != S_WRITE) res_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            act_q <= action;
            cmd_q <= command;
            state <= (action == ACT_SET) ? S_LOAD : S_WRITE;
          end
        end
        S_LOAD: state <= S_MUL;
        S_MUL: begin
          if (mul_done) state <= S_ADD;
        end
        S_ADD: state <= S_DIV;
        S_DIV: begin
          if (div_done) state <= S_WRITE;
        end
        S_WRITE: begin
          if (res_free) begin
            main_duty_reg    <= main_n;
            reverse_duty_reg <= rev_n;
            pulse_reg        <= pulse_n;
            bridge_pins      <= pins_n;
            direction_state  <= dir_n;
            running_flag     <= run_n;
            last_command     <= last_n;
            res_valid        <= 1'b1;
            main_duty        <= servo ? '0 : main_n;
            reverse_duty     <= (motor_mode == MODE_DUAL) ? rev_n : '0;
            pulse_width      <= servo ? pulse_n : '0;
            pin_in1          <= bridge & pins_n[PIN_IN1];
            pin_in2          <= bridge & pins_n[PIN_IN2];
            pin_standby      <= bridge & bridge_options[OPT_STBY] & pins_n[PIN_STBY];
            direction        <= dir_n;
            running          <= run_n;
            applied_command  <= last_n;
            state            <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- bench/motor_command_mapper_test.sv -----
// Self-checking testbench of the motor command mapper: directed table, then random phases.
module motor_command_mapper_test;
  timeunit 1ns;
  timeprecision 1ps;

  import mcm_pkg::*;

  localparam int CW = 16;
  localparam longint FULL = (longint'(1) << (CW - 1)) - 1;
  localparam int SETTLE = 48;
  localparam int LIMIT = 1000000;
  localparam int PHASES = 25;
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  typedef struct packed {
    word_t main_duty;
    word_t reverse_duty;
    word_t pulse_width;
    logic in1;
    logic in2;
    logic stby;
    logic [1:0] dir;
    logic run;
    logic signed [CW-1:0] applied;
  } drive_t;

  typedef struct {
    bit wr;
    logic [REG_IDX_W-1:0] idx;
    word_t data;
    logic [1:0] act;
    logic signed [CW-1:0] cmd;
    bit known;
    drive_t exp;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [REG_IDX_W-1:0] cfg_index = '0;
  logic [DATA_W-1:0] cfg_data = '0;
  logic cmd_valid = 1'b0;
  logic cmd_stall;
  logic [1:0] action = ACT_SET;
  logic signed [CW-1:0] command = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  logic [DATA_W-1:0] main_duty, reverse_duty, pulse_width;
  logic pin_in1, pin_in2, pin_standby, running;
  logic [1:0] direction;
  logic signed [CW-1:0] applied_command;

  // register shadows
  logic [1:0] mode_r = MODE_SINGLE;
  word_t min_r = 16'd0;
  word_t max_r = DUTY_FULL;
  logic signed [15:0] amin_r = DEF_ANGLE_MIN;
  logic signed [15:0] amax_r = DEF_ANGLE_MAX;
  word_t pmin_r = DEF_PULSE_MIN;
  word_t pmax_r = DEF_PULSE_MAX;
  logic [2:0] opt_r = 3'd0;

  // drive state as predicted
  logic run_q = 1'b0;
  logic [1:0] dir_q = DIR_STOP;
  word_t main_q = '0, rev_q = '0, pulse_q = '0;
  logic [2:0] pins_q = 3'b000;
  logic signed [CW-1:0] last_q = '0;

  drive_t predicted_drive[$];
  row_t plan[$];
  drive_t got, want;
  int failures = 0;
  int cycles = 0;
  bit send_calm = 1'b0;
  bit recv_calm = 1'b0;
  int stall_hold = 0;
  int stall_pick;

  motor_command_mapper #(.COMMAND_WIDTH(CW)) DUT (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .action(action), .command(command),
    .res_valid(res_valid), .res_stall(res_stall),
    .main_duty(main_duty), .reverse_duty(reverse_duty), .pulse_width(pulse_width),
    .pin_in1(pin_in1), .pin_in2(pin_in2), .pin_standby(pin_standby),
    .direction(direction), .running(running), .applied_command(applied_command)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles == LIMIT) begin
      $display("FAIL motor_command_mapper");
      $finish;
    end
  end

  function automatic drive_t drive(input word_t m, input word_t r, input word_t p,
                                   input logic i1, input logic i2, input logic sb,
                                   input logic [1:0] d, input logic rn,
                                   input logic signed [CW-1:0] a);
    drive_t v;
    v.main_duty = m; v.reverse_duty = r; v.pulse_width = p;
    v.in1 = i1; v.in2 = i2; v.stby = sb;
    v.dir = d; v.run = rn; v.applied = a;
    return v;
  endfunction

  function automatic void set_dir_pins(input bit fwd);
    logic to_in1;
    to_in1 = fwd ? !opt_r[OPT_SWAP] : opt_r[OPT_SWAP];
    pins_q = '0;
    pins_q[PIN_STBY] = 1'b1;
    if (to_in1) pins_q[PIN_IN1] = 1'b1;
    else pins_q[PIN_IN2] = 1'b1;
  endfunction

  // stop level: both high with brake, else low; standby untouched
  function automatic void park_pins();
    pins_q[PIN_IN1] = opt_r[OPT_BRAKE];
    pins_q[PIN_IN2] = opt_r[OPT_BRAKE];
  endfunction

  // advance the predicted drive state by one request and return what the block reports
  function automatic drive_t map_command(input logic [1:0] act,
                                         input logic signed [CW-1:0] cmd);
    longint c, lo, dmin, dmax, mag, duty, amin, amax, pmin, pmax, span;
    bit bridge;
    drive_t v;
    c = cmd;
    bridge = (mode_r == MODE_BRIDGE);
    case (act)
      ACT_SET: begin
        if (mode_r == MODE_SERVO) begin
          amin = amin_r; amax = amax_r; pmin = pmin_r; pmax = pmax_r;
          if (amax <= amin) begin
            amin = DEF_ANGLE_MIN; amax = DEF_ANGLE_MAX;
          end
          if (pmax <= pmin) begin
            pmin = DEF_PULSE_MIN; pmax = DEF_PULSE_MAX;
          end
          if (c < amin) c = amin;
          if (c > amax) c = amax;
          span = amax - amin;
          duty = pmin + (2 * (c - amin) * (pmax - pmin) + span) / (2 * span);
          pulse_q = duty[15:0];
          dir_q = DIR_STOP;
        end else begin
          lo = (mode_r == MODE_SINGLE) ? 0 : -FULL;
          dmin = min_r;
          dmax = (max_r != 0) ? max_r : DUTY_FULL;
          if (dmin > dmax) begin
            dmin = 0; dmax = DUTY_FULL;
          end
          if (c < lo) c = lo;
          if (c > FULL) c = FULL;
          mag = (c < 0) ? -c : c;
          duty = (mag == 0) ? 0 : dmin + ((dmax - dmin) * mag + FULL / 2) / FULL;
          if (c > 0) begin
            if (bridge) set_dir_pins(1'b1);
            main_q = duty[15:0]; rev_q = '0; dir_q = DIR_FWD;
          end else if (c < 0) begin
            if (bridge) begin
              set_dir_pins(1'b0);
              main_q = duty[15:0]; rev_q = '0;
            end else begin
              main_q = '0; rev_q = duty[15:0];
            end
            dir_q = DIR_REV;
          end else begin
            main_q = '0; rev_q = '0;
            if (bridge) park_pins();
            dir_q = DIR_STOP;
          end
        end
        last_q = c[CW-1:0];
      end
      ACT_START: begin
        run_q = 1'b1;
        pins_q[PIN_STBY] = 1'b1;
      end
      ACT_STOP: begin
        main_q = '0; rev_q = '0; pulse_q = '0;
        park_pins();
        if (!opt_r[OPT_BRAKE]) pins_q[PIN_STBY] = 1'b0;
        run_q = 1'b0; dir_q = DIR_STOP; last_q = '0;
      end
      default: ;
    endcase
    v.main_duty = (mode_r == MODE_SERVO) ? '0 : main_q;
    v.reverse_duty = (mode_r == MODE_DUAL) ? rev_q : '0;
    v.pulse_width = (mode_r == MODE_SERVO) ? pulse_q : '0;
    v.in1 = bridge && pins_q[PIN_IN1];
    v.in2 = bridge && pins_q[PIN_IN2];
    v.stby = bridge && opt_r[OPT_STBY] && pins_q[PIN_STBY];
    v.dir = dir_q;
    v.run = run_q;
    v.applied = last_q;
    return v;
  endfunction

  task automatic add_row(input bit wr, input logic [REG_IDX_W-1:0] idx, input word_t data,
                         input logic [1:0] act, input logic signed [CW-1:0] cmd,
                         input bit known, input drive_t exp);
    row_t r;
    r.wr = wr; r.idx = idx; r.data = data;
    r.act = act; r.cmd = cmd; r.known = known; r.exp = exp;
    plan.push_back(r);
  endtask

  // wait for every pending result, then for the block to go quiet
  task automatic settle_drive();
    while (predicted_drive.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input word_t data);
    cmd_valid <= 1'b0;
    settle_drive();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_MODE:       mode_r = data[1:0];
      REG_DUTY_FLOOR: min_r = data;
      REG_DUTY_CEIL:  max_r = data;
      REG_ANGLE_MIN:  amin_r = data;
      REG_ANGLE_MAX:  amax_r = data;
      REG_PULSE_MIN:  pmin_r = data;
      REG_PULSE_MAX:  pmax_r = data;
      REG_OPTIONS:    opt_r = data[2:0];
      default: ;
    endcase
  endtask

  function automatic word_t extreme_word();
    case ($urandom_range(0, 4))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h8000;
      3: return 16'h7FFF;
      default: return word_t'($urandom);
    endcase
  endfunction

  // mostly an ordered pair, sometimes extremes in any order (fallback cases)
  task automatic write_pair(input logic [REG_IDX_W-1:0] lo_idx,
                            input logic [REG_IDX_W-1:0] hi_idx, input bit signed_pair);
    word_t a, b, t;
    if ($urandom_range(0, 3) == 0) begin
      a = extreme_word();
      b = extreme_word();
    end else begin
      a = word_t'($urandom);
      b = word_t'($urandom);
      if (signed_pair ? ($signed(a) > $signed(b)) : (a > b)) begin
        t = a; a = b; b = t;
      end
    end
    write_reg(lo_idx, a);
    write_reg(hi_idx, b);
  endtask

  task automatic send(input logic [1:0] act, input logic signed [CW-1:0] cmd,
                      input bit known, input drive_t lit);
    int gap, pick;
    drive_t pred;
    pick = $urandom_range(0, 99);
    if (send_calm || pick < 60) gap = 0;
    else if (pick < 92) gap = $urandom_range(1, 3);
    else gap = $urandom_range(10, 40);
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd_valid <= 1'b1;
    action <= act;
    command <= cmd;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    pred = map_command(act, cmd);
    predicted_drive.push_back(known ? lit : pred);
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
    end else if (stall_hold > 0) begin
      stall_hold--;
    end else begin
      stall_pick = $urandom_range(0, 99);
      if (recv_calm || stall_pick < 55) begin
        res_stall <= 1'b0;
        stall_hold = recv_calm ? 0 : $urandom_range(0, 3);
      end else if (stall_pick < 92) begin
        res_stall <= 1'b1;
        stall_hold = $urandom_range(0, 2);
      end else begin
        res_stall <= 1'b1;
        stall_hold = $urandom_range(10, 40);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) begin
      got.main_duty = main_duty;
      got.reverse_duty = reverse_duty;
      got.pulse_width = pulse_width;
      got.in1 = pin_in1;
      got.in2 = pin_in2;
      got.stby = pin_standby;
      got.dir = direction;
      got.run = running;
      got.applied = applied_command;
      if (predicted_drive.size() == 0) begin
        failures++;
        if (failures <= 10) $display("result with no request pending at cycle %0d", cycles);
      end else begin
        want = predicted_drive.pop_front();
        if (got !== want) begin
          failures++;
          if (failures <= 10)
            $display({"mismatch cycle %0d: main %0d/%0d rev %0d/%0d pulse %0d/%0d ",
                      "in1 %b/%b in2 %b/%b stby %b/%b dir %0d/%0d run %b/%b cmd %0d/%0d"},
                     cycles, want.main_duty, got.main_duty,
                     want.reverse_duty, got.reverse_duty,
                     want.pulse_width, got.pulse_width, want.in1, got.in1,
                     want.in2, got.in2, want.stby, got.stby, want.dir, got.dir,
                     want.run, got.run, want.applied, got.applied);
        end
      end
    end
  end

  initial begin
    int n, pick;
    logic [1:0] act;
    logic signed [CW-1:0] cmd, small_mag;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // single PWM at reset values
    add_row(0, REG_MODE, 0, ACT_SET, 0, 1, drive(0, 0, 0, 0, 0, 0, DIR_STOP, 0, 0));
    add_row(0, REG_MODE, 0, ACT_START, 0, 1, drive(0, 0, 0, 0, 0, 0, DIR_STOP, 1, 0));
    add_row(0, REG_MODE, 0, ACT_SET, 32767, 1,
            drive(65535, 0, 0, 0, 0, 0, DIR_FWD, 1, 32767));
    add_row(0, REG_MODE, 0, ACT_SET, -32768, 1, drive(0, 0, 0, 0, 0, 0, DIR_STOP, 1, 0));
    add_row(0, REG_MODE, 0, ACT_SET, 1, 0, '0);
    // zero max duty, then min above max
    add_row(1, REG_DUTY_CEIL, 0, ACT_SET, 32767, 1,
            drive(65535, 0, 0, 0, 0, 0, DIR_FWD, 1, 32767));
    add_row(1, REG_DUTY_FLOOR, 40000, ACT_SET, 1, 0, '0);
    add_row(1, REG_DUTY_CEIL, 1000, ACT_SET, 16384, 0, '0);
    add_row(0, REG_MODE, 0, ACT_STOP, 0, 1, drive(0, 0, 0, 0, 0, 0, DIR_STOP, 0, 0));
    // forward/reverse PWM, most negative speed saturates
    add_row(1, REG_MODE, word_t'(MODE_DUAL), ACT_SET, -32768, 1,
            drive(0, 65535, 0, 0, 0, 0, DIR_REV, 0, -16'sd32767));
    add_row(1, REG_DUTY_CEIL, 50000, ACT_SET, -100, 0, '0);
    add_row(0, REG_MODE, 0, ACT_UNUSED, 123, 0, '0);
    // bridge pins: plain, swapped with standby, brake on stop
    add_row(1, REG_MODE, word_t'(MODE_BRIDGE), ACT_SET, 32767, 1,
            drive(50000, 0, 0, 1, 0, 0, DIR_FWD, 0, 32767));
    add_row(1, REG_OPTIONS, 5, ACT_SET, -32767, 1,
            drive(50000, 0, 0, 1, 0, 1, DIR_REV, 0, -16'sd32767));
    add_row(0, REG_MODE, 0, ACT_START, 0, 0, '0);
    add_row(1, REG_OPTIONS, 6, ACT_STOP, 0, 1, drive(0, 0, 0, 1, 1, 1, DIR_STOP, 0, 0));
    add_row(0, REG_MODE, 0, ACT_SET, 0, 0, '0);
    add_row(1, REG_OPTIONS, 0, ACT_STOP, 0, 0, '0);
    // servo at default ranges, then the fallback ranges
    add_row(1, REG_MODE, word_t'(MODE_SERVO), ACT_SET, -32768, 1,
            drive(0, 0, 5000, 0, 0, 0, DIR_STOP, 0, 0));
    add_row(0, REG_MODE, 0, ACT_SET, 32767, 1,
            drive(0, 0, 25000, 0, 0, 0, DIR_STOP, 0, 18000));
    add_row(0, REG_MODE, 0, ACT_SET, 9000, 1, drive(0, 0, 15000, 0, 0, 0, DIR_STOP, 0, 9000));
    add_row(1, REG_ANGLE_MIN, 18000, ACT_SET, 1, 0, '0);
    add_row(1, REG_ANGLE_MAX, 16'h7FFF, ACT_SET, -32768, 0, '0);
    add_row(1, REG_PULSE_MIN, 30000, ACT_SET, 32767, 0, '0);
    add_row(1, REG_PULSE_MAX, 16'hFFFF, ACT_START, 0, 0, '0);
    add_row(0, REG_MODE, 0, ACT_STOP, 0, 0, '0);

    foreach (plan[i]) begin
      if (plan[i].wr) write_reg(plan[i].idx, plan[i].data);
      send(plan[i].act, plan[i].cmd, plan[i].known, plan[i].exp);
    end

    for (int p = 0; p < PHASES; p++) begin
      send_calm = ($urandom_range(0, 3) == 0);
      recv_calm = ($urandom_range(0, 3) == 0);
      write_reg(REG_MODE, (p < 8) ? word_t'(p % 4) : word_t'($urandom_range(0, 3)));
      if ($urandom_range(0, 2) != 0) write_pair(REG_DUTY_FLOOR, REG_DUTY_CEIL, 1'b0);
      if ($urandom_range(0, 2) != 0) write_pair(REG_ANGLE_MIN, REG_ANGLE_MAX, 1'b1);
      if ($urandom_range(0, 2) != 0) write_pair(REG_PULSE_MIN, REG_PULSE_MAX, 1'b0);
      if ($urandom_range(0, 1) != 0) write_reg(REG_OPTIONS, word_t'($urandom_range(0, 7)));
      n = $urandom_range(50, 72);
      repeat (n) begin
        pick = $urandom_range(0, 99);
        if (pick < 72) act = ACT_SET;
        else if (pick < 84) act = ACT_START;
        else if (pick < 96) act = ACT_STOP;
        else act = ACT_UNUSED;
        small_mag = CW'($urandom_range(1, 300));
        case ($urandom_range(0, 9))
          0: cmd = 16'sh8000;
          1: cmd = 16'sh7FFF;
          2: cmd = '0;
          3: cmd = $urandom_range(0, 1) ? 16'sd1 : -16'sd1;
          4: cmd = $urandom_range(0, 1) ? small_mag : -small_mag;
          5: cmd = CW'($urandom_range(0, 18000));
          default: cmd = CW'($urandom);
        endcase
        send(act, cmd, 1'b0, '0);
      end
    end

    cmd_valid <= 1'b0;
    settle_drive();
    if (failures == 0) begin
      $display("PASS motor_command_mapper");
    end else begin
      $display("FAIL motor_command_mapper");
    end
    $finish;
  end

endmodule
